FILE: hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants for the quadratic root solver
// Root kind codes and the fixed result width.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // result value width, Q23.16 at the default fraction width
  localparam int VALUE_WIDTH = 40;
  localparam int KIND_WIDTH  = 2;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_A_ZERO   = 2'd3
  } root_kind_t;

endpackage

FILE: hdl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front: coefficient intake and classification
// Registers |a|*|c|, b*b, -b*2^F and 2a, then forms |D| and the root kind.
// ----------------------------------------------------------------------------
module qrs_front #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COEF_WIDTH-1:0]         coef_a,
  input  logic signed [COEF_WIDTH-1:0]         coef_b,
  input  logic signed [COEF_WIDTH-1:0]         coef_c,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output qrs_pkg::root_kind_t                  out_kind,
  output logic        [2*COEF_WIDTH:0]         out_dmag,
  output logic signed [COEF_WIDTH+FRAC_BITS:0] out_nb,
  output logic signed [COEF_WIDTH:0]           out_den
);
  import qrs_pkg::*;

  localparam int W   = COEF_WIDTH;
  localparam int PW2 = 2 * W;
  localparam int DW  = 2 * W + 1;
  localparam int NBW = W + FRAC_BITS + 1;

  logic                v_r;
  logic                azero_r;
  logic                negac_r;
  logic [PW2-1:0]      prod_r;
  logic [PW2-1:0]      bsq_r;
  logic signed [NBW-1:0] nb_r;
  logic signed [W:0]   den_r;

  logic [W-1:0]   mag_a, mag_b, mag_c;
  logic [PW2+1:0] four_ac, bsq_x, d_full;
  logic           d_neg;

  // operand magnitudes
  assign mag_a = coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
  assign mag_b = coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
  assign mag_c = coef_c[W-1] ? W'(-coef_c) : W'(coef_c);

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r  <= PW2'(mag_a) * PW2'(mag_c);
      bsq_r   <= PW2'(mag_b) * PW2'(mag_b);
      negac_r <= coef_a[W-1] ^ coef_c[W-1];
      azero_r <= (coef_a == '0);
      nb_r    <= -(NBW'(coef_b) <<< FRAC_BITS);
      den_r   <= {coef_a, 1'b0};
    end
  end

  // discriminant magnitude and sign
  assign four_ac = {prod_r, 2'b00};
  assign bsq_x   = {2'b00, bsq_r};

  always_comb begin
    d_neg = 1'b0;
    if (negac_r) begin
      d_full = bsq_x + four_ac;
    end else if (four_ac <= bsq_x) begin
      d_full = bsq_x - four_ac;
    end else begin
      d_full = four_ac - bsq_x;
      d_neg  = 1'b1;
    end
  end

  // classify
  always_comb begin
    if (azero_r) begin
      out_kind = KIND_A_ZERO;
    end else if (d_full == '0) begin
      out_kind = KIND_DOUBLE;
    end else if (d_neg) begin
      out_kind = KIND_COMPLEX;
    end else begin
      out_kind = KIND_TWO_REAL;
    end
  end

  assign out_dmag = DW'(d_full);
  assign out_nb   = nb_r;
  assign out_den  = den_r;

endmodule

FILE: hdl/qrs_queue.sv
// ----------------------------------------------------------------------------
// qrs_queue: short queue between classification and the solve pipeline
// Four entries, pointer based; either side may stall independently.
// ----------------------------------------------------------------------------
module qrs_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);
  import qrs_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_r, rd_r;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_ready  = (cnt_r != (AW+1)'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= in_data;
    end
  end

endmodule

FILE: hdl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root of |D| * 4^F
// One root bit per stage, restoring digit method; sideband rides along.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = 16,
  parameter int SB_W      = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [IN_W-1:0]                       in_val,
  input  logic [SB_W-1:0]                       in_side,
  output logic                                  out_valid,
  output logic [(IN_W+2*FRAC_BITS+1)/2-1:0]     out_root,
  output logic [SB_W-1:0]                       out_side
);
  import qrs_pkg::*;

  localparam int RW = (IN_W + 2 * FRAC_BITS + 1) / 2;
  localparam int PW = 2 * RW;

  logic          v_r    [RW];
  logic [PW-1:0] x_r    [RW];
  logic [RW:0]   rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SB_W-1:0] sb_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_cur;
    logic [PW-1:0]   x_cur;
    logic [RW:0]     rem_cur;
    logic [RW-1:0]   root_cur;
    logic [SB_W-1:0] sb_cur;
    logic [RW+2:0]   remx, trial, diff;
    logic            ge;

    if (k == 0) begin : g_head
      assign v_cur    = in_valid;
      assign x_cur    = PW'(in_val) << (2 * FRAC_BITS);
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign sb_cur   = in_side;
    end else begin : g_body
      assign v_cur    = v_r[k-1];
      assign x_cur    = x_r[k-1];
      assign rem_cur  = rem_r[k-1];
      assign root_cur = root_r[k-1];
      assign sb_cur   = sb_r[k-1];
    end

    // bring down the next bit pair, try (root*4 + 1)
    assign remx  = {rem_cur, x_cur[PW-1 -: 2]};
    assign trial = {1'b0, root_cur, 2'b01};
    assign ge    = (remx >= trial);
    assign diff  = remx - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_cur << 2;
        rem_r[k]  <= ge ? diff[RW:0] : remx[RW:0];
        root_r[k] <= {root_cur[RW-2:0], ge};
        sb_r[k]   <= sb_cur;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = sb_r[RW-1];

endmodule

FILE: hdl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage; sideband rides along.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 17,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_side,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [SB_W-1:0]  out_side
);
  import qrs_pkg::*;

  logic             v_r   [NUM_W];
  logic [NUM_W-1:0] n_r   [NUM_W];
  logic [DEN_W-1:0] d_r   [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] q_r   [NUM_W];
  logic [SB_W-1:0]  sb_r  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             v_cur;
    logic [NUM_W-1:0] n_cur;
    logic [DEN_W-1:0] d_cur;
    logic [DEN_W-1:0] rem_cur;
    logic [NUM_W-1:0] q_cur;
    logic [SB_W-1:0]  sb_cur;
    logic [DEN_W:0]   remx, dx, diff;
    logic             ge;

    if (k == 0) begin : g_head
      assign v_cur   = in_valid;
      assign n_cur   = in_num;
      assign d_cur   = in_den;
      assign rem_cur = '0;
      assign q_cur   = '0;
      assign sb_cur  = in_side;
    end else begin : g_body
      assign v_cur   = v_r[k-1];
      assign n_cur   = n_r[k-1];
      assign d_cur   = d_r[k-1];
      assign rem_cur = rem_r[k-1];
      assign q_cur   = q_r[k-1];
      assign sb_cur  = sb_r[k-1];
    end

    // shift in the next numerator bit and try a subtract
    assign remx = {rem_cur, n_cur[NUM_W-1]};
    assign dx   = {1'b0, d_cur};
    assign ge   = (remx >= dx);
    assign diff = remx - dx;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= n_cur << 1;
        d_r[k]   <= d_cur;
        rem_r[k] <= ge ? diff[DEN_W-1:0] : remx[DEN_W-1:0];
        q_r[k]   <= {q_cur[NUM_W-2:0], ge};
        sb_r[k]  <= sb_cur;
      end
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign out_quo   = q_r[NUM_W-1];
  assign out_side  = sb_r[NUM_W-1];

endmodule

FILE: hdl/quadratic_root_solver.sv
// Register order, input to result: front, queue, sqrt, numerator, divider, output;
//   RW = (2*COEF_WIDTH + 2*FRAC_BITS + 2)/2 square root stages and NW = max(COEF_WIDTH +
//   FRAC_BITS + 1, RW + 1) + 1 divider stages.
// Throughput: one beat per cycle (one bit per pipe stage) unless out_tready stalls.
// Reset: rst_n synchronous active low clears all valid flags and the queue; no clearing pass.
// ----------------------------------------------------------------------------
// quadratic_root_solver: roots of a*x^2 + b*x + c in signed fixed point
// Front classifies into a short queue; back runs sqrt, divide and saturate.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // coef_a, coef_b, coef_c from bit 0 up
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // first_value, second_value from bit 0 up
  output logic [2*qrs_pkg::VALUE_WIDTH-1:0]     out_tdata,
  // root_kind
  output logic [qrs_pkg::KIND_WIDTH-1:0]        out_tuser
);
  import qrs_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int DW   = 2 * W + 1;
  localparam int NBW  = W + FRAC_BITS + 1;
  localparam int DENW = W + 1;
  localparam int RW   = (DW + 2 * FRAC_BITS + 1) / 2;
  localparam int SW   = ((NBW > RW + 1) ? NBW : RW + 1) + 1;
  localparam int NW   = SW;
  localparam int EW   = (NW + 1 > VALUE_WIDTH) ? NW + 1 : VALUE_WIDTH;
  localparam int QW   = KIND_WIDTH + DW + NBW + DENW;
  localparam int SBS  = KIND_WIDTH + NBW + DENW;

  localparam logic signed [EW-1:0] MAXV =
    {{(EW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [EW-1:0] MINV = ~MAXV;

  // front to queue
  logic                   f_valid, f_ready;
  root_kind_t             f_kind;
  logic [DW-1:0]          f_dmag;
  logic signed [NBW-1:0]  f_nb;
  logic signed [DENW-1:0] f_den;

  // queue to back
  logic          q_valid;
  logic [QW-1:0] q_data;

  // back pipe
  logic                   en;
  logic                   s_valid;
  logic [RW-1:0]          s_root;
  logic [SBS-1:0]         s_side;
  root_kind_t             s_kind;
  logic signed [NBW-1:0]  s_nb;
  logic signed [DENW-1:0] s_den;

  logic signed [SW-1:0] nbx, sx, n1, n2;
  logic [NW-1:0]        m1, m2;
  logic [DENW-1:0]      dm;

  logic                  c_v_r;
  logic [NW-1:0]         c_n1_r, c_n2_r;
  logic [DENW-1:0]       c_d_r;
  logic [KIND_WIDTH-1:0] c_k_r;
  logic                  c_neg1_r, c_neg2_r;

  logic                    d1_valid, d2_valid;
  logic [NW-1:0]           q1, q2;
  logic [KIND_WIDTH:0]     d1_side;
  logic                    d2_side;
  root_kind_t              d_kind;
  logic signed [EW-1:0]    v1, v2;
  logic [VALUE_WIDTH-1:0]  sat1, sat2;

  logic                   out_v_r;
  logic [KIND_WIDTH-1:0]  kind_r;
  logic [VALUE_WIDTH-1:0] first_r, second_r;

  qrs_front #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .coef_a    ($signed(in_tdata[W-1:0])),
    .coef_b    ($signed(in_tdata[2*W-1:W])),
    .coef_c    ($signed(in_tdata[3*W-1:2*W])),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_kind  (f_kind),
    .out_dmag  (f_dmag),
    .out_nb    (f_nb),
    .out_den   (f_den)
  );

  qrs_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_kind, f_dmag, f_nb, f_den}),
    .out_valid (q_valid),
    .out_ready (en),
    .out_data  (q_data)
  );

  // whole back pipe advances while the output register can take a beat
  assign en = !out_v_r || out_tready;

  qrs_sqrt #(
    .IN_W      (DW),
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SBS)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_val    (q_data[NBW+DENW +: DW]),
    .in_side   ({q_data[QW-1 -: KIND_WIDTH], q_data[NBW+DENW-1:0]}),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  assign s_kind = root_kind_t'(s_side[SBS-1 -: KIND_WIDTH]);
  assign s_nb   = $signed(s_side[NBW+DENW-1:DENW]);
  assign s_den  = $signed(s_side[DENW-1:0]);

  // numerators per root kind, then magnitudes
  assign nbx = SW'(s_nb);
  assign sx  = $signed(SW'(s_root));
  assign n1  = (s_kind == KIND_COMPLEX) ? nbx : nbx + sx;
  assign n2  = (s_kind == KIND_COMPLEX) ? sx : nbx - sx;
  assign m1  = n1[SW-1] ? NW'(-n1) : NW'(n1);
  assign m2  = n2[SW-1] ? NW'(-n2) : NW'(n2);
  assign dm  = s_den[DENW-1] ? DENW'(-s_den) : DENW'(s_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_n1_r   <= m1;
      c_n2_r   <= m2;
      c_d_r    <= dm;
      c_k_r    <= s_kind;
      c_neg1_r <= n1[SW-1] ^ s_den[DENW-1];
      c_neg2_r <= n2[SW-1] ^ s_den[DENW-1];
    end
  end

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (DENW),
    .SB_W  (KIND_WIDTH + 1)
  ) u_div_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_num    (c_n1_r),
    .in_den    (c_d_r),
    .in_side   ({c_k_r, c_neg1_r}),
    .out_valid (d1_valid),
    .out_quo   (q1),
    .out_side  (d1_side)
  );

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (DENW),
    .SB_W  (1)
  ) u_div_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_num    (c_n2_r),
    .in_den    (c_d_r),
    .in_side   (c_neg2_r),
    .out_valid (d2_valid),
    .out_quo   (q2),
    .out_side  (d2_side)
  );

  // restore sign and saturate to the result range
  assign d_kind = root_kind_t'(d1_side[KIND_WIDTH:1]);
  assign v1 = d1_side[0] ? -$signed(EW'(q1)) : $signed(EW'(q1));
  assign v2 = d2_side    ? -$signed(EW'(q2)) : $signed(EW'(q2));

  always_comb begin
    if (v1 > MAXV) begin
      sat1 = VALUE_WIDTH'(MAXV);
    end else if (v1 < MINV) begin
      sat1 = VALUE_WIDTH'(MINV);
    end else begin
      sat1 = VALUE_WIDTH'(v1);
    end
    if (v2 > MAXV) begin
      sat2 = VALUE_WIDTH'(MAXV);
    end else if (v2 < MINV) begin
      sat2 = VALUE_WIDTH'(MINV);
    end else begin
      sat2 = VALUE_WIDTH'(v2);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && d1_valid) begin
      kind_r <= d_kind;
      if (d_kind == KIND_A_ZERO) begin
        first_r  <= '0;
        second_r <= '0;
      end else begin
        first_r  <= sat1;
        second_r <= sat2;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {second_r, first_r};
  assign out_tuser  = kind_r;

  // both dividers stay in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    d1_valid == d2_valid)
    else $error("divider valid flags diverged");

  // zero leading coefficient gives zero values
  a_azero_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_A_ZERO) |-> (out_tdata == '0))
    else $error("a-zero beat carries nonzero values");

  // a double root reports the same value twice
  a_double_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DOUBLE) |->
      (out_tdata[VALUE_WIDTH-1:0] == out_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]))
    else $error("double root values differ");

endmodule

FILE: tb/tb_quadratic_root_solver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver: stream-level check of the quadratic root solver
// Coefficient beats are driven from a queue with random gaps and back pressure.
// Each result beat is checked against roots predicted in the bench itself.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int CW    = 16;
  localparam int FB    = 16;
  localparam int VW    = VALUE_WIDTH;
  localparam int IN_W  = ((3*CW+7)/8)*8;
  localparam int LAT   = 71;
  localparam int N_RND = 1300;

  // field order matches the input beat, c in the top bits
  typedef struct packed {
    logic [CW-1:0] c;
    logic [CW-1:0] b;
    logic [CW-1:0] a;
  } coef_set_t;

  typedef struct packed {
    root_kind_t    kind;
    logic [VW-1:0] first;
    logic [VW-1:0] second;
  } roots_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [2*VW-1:0] out_tdata;
  logic [KIND_WIDTH-1:0] out_tuser;

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  int        n_errors = 0;
  bit        quiet_tail = 0;
  bit        stim_done = 0;
  bit        in_taken = 0;
  int        send_gap = 0;
  int        recv_stall = 0;

  quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // truncating divide, then clamp to the signed value range
  function automatic logic [VW-1:0] clamp_quot(logic signed [127:0] num,
                                               logic signed [127:0] den);
    logic signed [127:0] q;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    begin
      q  = num / den;
      hi = (128'sd1 <<< (VW-1)) - 1;
      lo = -hi - 1;
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[VW-1:0];
    end
  endfunction

  // floor of the square root, bit by bit
  function automatic logic [127:0] floor_sqrt(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] t;
    int i;
    begin
      r = '0;
      for (i = 63; i >= 0; i--) begin
        t = r | (128'd1 << i);
        if (t * t <= v) r = t;
      end
      return r;
    end
  endfunction

  function automatic roots_t solve_roots(coef_set_t s);
    logic signed [127:0] a, b, c, d, nb, den, sq;
    roots_t r;
    begin
      a = $signed(s.a);
      b = $signed(s.b);
      c = $signed(s.c);
      r = '0;
      if (a == 0) begin
        r.kind = KIND_A_ZERO;
        return r;
      end
      d   = b*b - 4*a*c;
      nb  = -(b <<< FB);
      den = 2*a;
      if (d == 0) begin
        r.kind   = KIND_DOUBLE;
        r.first  = clamp_quot(nb, den);
        r.second = r.first;
      end else if (d > 0) begin
        sq       = $signed(floor_sqrt(d << (2*FB)));
        r.kind   = KIND_TWO_REAL;
        r.first  = clamp_quot(nb + sq, den);
        r.second = clamp_quot(nb - sq, den);
      end else begin
        sq       = $signed(floor_sqrt((-d) << (2*FB)));
        r.kind   = KIND_COMPLEX;
        r.first  = clamp_quot(nb, den);
        r.second = clamp_quot(sq, den);
      end
      return r;
    end
  endfunction

  task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
    begin
      n_errors++;
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    end
  endtask

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return CW'($signed($urandom_range(0, 6)) - 3);
      3: return CW'($signed($urandom_range(0, 200)) - 100);
      default: return CW'($urandom);
    endcase
  endfunction

  // driver: offer the next coefficient beat, with random send gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(pending_sets.pop_front());
      end
      if (!(in_tvalid && !in_taken)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_sets.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'({pending_sets[0].c, pending_sets[0].b, pending_sets[0].a});
          if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      // receiver back pressure
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 9) == 0) recv_stall <= $urandom_range(1, 7);
      end
    end
  end

  // input monitor: predict on each accepted beat
  always @(posedge clk) begin
    coef_set_t s;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      s = in_tdata[3*CW-1:0];
      expected_roots.push_back(solve_roots(s));
    end
  end

  // output monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    roots_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[VW-1:0], '0);
      end else begin
        want = expected_roots.pop_front();
        if (out_tuser != want.kind) report_mismatch("root_kind", VW'(out_tuser), VW'(want.kind));
        if (out_tdata[VW-1:0] != want.first)
          report_mismatch("first_value", out_tdata[VW-1:0], want.first);
        if (out_tdata[2*VW-1:VW] != want.second)
          report_mismatch("second_value", out_tdata[2*VW-1:VW], want.second);
      end
    end
  end

  function automatic coef_set_t mk(int a, int b, int c);
    coef_set_t s;
    begin
      s.a = CW'(a); s.b = CW'(b); s.c = CW'(c);
      return s;
    end
  endfunction

  initial begin
    int i, k;
    int a;
    coef_set_t s;
    // directed: kinds, extremes, negative a, saturation
    pending_sets.push_back(mk(1, -3, 2));
    pending_sets.push_back(mk(1, 2, 1));
    pending_sets.push_back(mk(1, 0, 1));
    pending_sets.push_back(mk(0, 5, 7));
    pending_sets.push_back(mk(0, -32768, -32768));
    pending_sets.push_back(mk(-1, 3, 4));
    pending_sets.push_back(mk(-2, 1, -5));
    pending_sets.push_back(mk(1, -32768, -32768));
    pending_sets.push_back(mk(1, 32767, 32767));
    pending_sets.push_back(mk(-32768, -32768, -32768));
    pending_sets.push_back(mk(32767, 32767, 32767));
    pending_sets.push_back(mk(-32768, 32767, 32767));
    pending_sets.push_back(mk(32767, -32768, -32768));
    pending_sets.push_back(mk(1, -32768, 0));
    pending_sets.push_back(mk(-1, -32768, 0));
    pending_sets.push_back(mk(1, 32767, -32768));
    pending_sets.push_back(mk(4, 4, 1));
    pending_sets.push_back(mk(-3, 0, 0));
    pending_sets.push_back(mk(1, 0, -32768));
    pending_sets.push_back(mk(-32768, 0, 32767));
    pending_sets.push_back(mk(16'hffff, 16'hffff, 16'hffff));
    pending_sets.push_back(mk(16'h5555, 16'haaaa, 16'h5555));
    pending_sets.push_back(mk(16'haaaa, 16'h5555, 16'haaaa));
    // random coefficient sets, with double roots planted now and then
    for (i = 0; i < N_RND; i++) begin
      s.a = rand_coef(); s.b = rand_coef(); s.c = rand_coef();
      if ($urandom_range(0, 9) == 0) begin
        k = $signed($urandom_range(0, 60)) - 30;
        a = $signed($urandom_range(0, 40)) - 20;
        s.a = CW'(a); s.b = CW'(-2*a*k); s.c = CW'(a*k*k);
      end
      pending_sets.push_back(s);
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_sets.size() < 200);
    quiet_tail = 1;
    wait (pending_sets.size() == 0 && !in_tvalid);
    wait (expected_roots.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    stim_done = 1;
    if (n_errors == 0) begin
      $display("tb_quadratic_root_solver: done, clean");
    end else begin
      $display("tb_quadratic_root_solver: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    if (!stim_done) begin
      $display("tb_quadratic_root_solver: done, errors");
      $finish;
    end
  end

endmodule
